// ===== src/iolh_pkg.sv =====
// Shared types, constants and codes for the immediate log2 histogram.
package iolh_pkg;

   localparam int NUM_TYPES   = 10;
   localparam int NUM_BINS    = 65;
   localparam int COUNT_WIDTH = 48;
   localparam int NUM_CLASSES = 2;
   localparam int MEM_DEPTH   = NUM_CLASSES * NUM_TYPES * NUM_BINS;
   localparam int ADDR_W      = $clog2(MEM_DEPTH);
   localparam int OUT_COUNT_W = 48;
   localparam int TYPE_SHIFT  = 28;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [3:0] TYPE_NONE = 4'd0;
   localparam logic [3:0] TYPE_U10  = 4'd1;
   localparam logic [3:0] TYPE_U15  = 4'd2;
   localparam logic [3:0] TYPE_S16A = 4'd3;
   localparam logic [3:0] TYPE_U16A = 4'd4;
   localparam logic [3:0] TYPE_U16B = 4'd5;
   localparam logic [3:0] TYPE_S16B = 4'd6;
   localparam logic [3:0] TYPE_S16C = 4'd7;
   localparam logic [3:0] TYPE_BR16 = 4'd8;
   localparam logic [3:0] TYPE_BR26 = 4'd9;

   typedef struct packed {
      logic        cmd;
      logic [31:0] offset_word;
      logic        histo_select;
      logic [15:0] increment;
      logic [3:0]  read_type;
      logic [6:0]  read_bin;
   } iolh_req_type;

   typedef struct packed {
      logic [6:0]             bin_index;
      logic [3:0]             type_code;
      logic [OUT_COUNT_W-1:0] count_value;
      logic                   no_immediate;
      logic                   bad_type;
   } iolh_rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [6:0]        bin_index;
      logic [3:0]        type_code;
      logic              no_immediate;
      logic              bad_type;
      logic              add_ok;
      logic              read_ok;
   } iolh_dec_type;

endpackage

// ===== src/iolh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module iolh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/iolh_decode.sv =====
// Immediate decode, log2 bucket encoder and counter address for one item.
module iolh_decode (
   input  iolh_pkg::iolh_req_type item,
   output iolh_pkg::iolh_dec_type dec
);
   import iolh_pkg::*;

   localparam logic [ADDR_W-1:0] CLASS_STRIDE = ADDR_W'(NUM_TYPES * NUM_BINS);
   localparam logic [ADDR_W-1:0] ROW_STRIDE   = ADDR_W'(NUM_BINS);

   function automatic logic [5:0] bit_len(input logic [31:0] x);
      logic [5:0] n;
      n = '0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) begin
            n = 6'(i + 1);
         end
      end
      return n;
   endfunction

   logic [3:0]  word_type;
   logic [31:0] value;
   logic [31:0] mag26;
   logic [6:0]  bucket;
   logic [3:0]  row_type;
   logic [6:0]  row_bin;
   logic        add_known;

   always_comb begin
      word_type = item.offset_word[TYPE_SHIFT +: 4];
      mag26     = item.offset_word & 32'h01FF_FFFC;
      case (word_type) inside
         TYPE_U10: value = item.offset_word & 32'h0000_03FF;
         TYPE_U15: value = item.offset_word & 32'h0000_7FFF;
         TYPE_S16A, TYPE_S16B, TYPE_S16C:
            value = {{16{item.offset_word[15]}}, item.offset_word[15:0]};
         TYPE_U16A, TYPE_U16B: value = item.offset_word & 32'h0000_FFFF;
         TYPE_BR16:
            value = {{16{item.offset_word[15]}}, item.offset_word[15:2], 2'b00};
         default: begin
            if (item.offset_word[25]) begin
               value = (mag26 == '0) ? 32'hFE00_0000 : 32'(32'd0 - mag26);
            end else begin
               value = mag26;
            end
         end
      endcase

      if (value[31]) begin
         bucket = 7'd64 - {1'b0, bit_len(~value)};
      end else begin
         bucket = {1'b0, bit_len(value)};
      end

      add_known = (word_type <= TYPE_BR26) &&
                  ({1'b0, word_type} < 5'(NUM_TYPES));

      dec = '0;
      if (item.cmd == CMD_ADD) begin
         dec.type_code    = word_type;
         dec.no_immediate = (word_type == TYPE_NONE);
         dec.bad_type     = (word_type != TYPE_NONE) && !add_known;
         dec.add_ok       = (word_type != TYPE_NONE) && add_known;
         dec.bin_index    = dec.add_ok ? bucket : '0;
         row_type         = word_type;
         row_bin          = bucket;
      end else begin
         dec.type_code = item.read_type;
         dec.bin_index = item.read_bin;
         dec.bad_type  = ({1'b0, item.read_type} >= 5'(NUM_TYPES));
         dec.read_ok   = !dec.bad_type && (item.read_bin < 7'(NUM_BINS));
         row_type      = item.read_type;
         row_bin       = item.read_bin;
      end

      dec.addr = (item.histo_select ? CLASS_STRIDE : '0)
               + ADDR_W'(row_type) * ROW_STRIDE
               + ADDR_W'(row_bin);
   end

endmodule

// ===== src/immediate_offset_log2_histogram.sv =====
// Top level: two-class log2 bucket histogram of immediates, counters in one RAM.
// Steps: S_ADDR decodes and reads the RAM, S_READ updates and registers the result.
// A new item is taken only in S_IDLE, once the counter read-modify-write is done.
// A result waiting at the output does not block the next accept; the update stalls then.
// Reset: synchronous; then every RAM entry is swept to zero, with req_ready low.
module immediate_offset_log2_histogram (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  iolh_pkg::iolh_req_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output iolh_pkg::iolh_rsp_type rsp_item
);
   import iolh_pkg::*;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_ADDR  = 2'd2;
   localparam logic [1:0] S_READ  = 2'd3;

   localparam int SUM_W = COUNT_WIDTH + 1;

   logic [1:0]             state_ff, state_in;
   logic [ADDR_W-1:0]      clr_ff, clr_in;
   iolh_req_type           item_ff, item_in;
   iolh_dec_type           dec, dec_ff, dec_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   iolh_rsp_type           rsp_item_ff, rsp_item_in;

   logic                   slot_free;
   logic                   finish;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic [ADDR_W-1:0]      rd_addr;
   logic [COUNT_WIDTH-1:0] rd_data;
   logic [SUM_W-1:0]       sum;
   logic [COUNT_WIDTH-1:0] sat;
   logic [COUNT_WIDTH-1:0] cnt;
   logic [63:0]            cnt_wide;

   iolh_decode u_decode (
      .item (item_ff),
      .dec  (dec)
   );

   iolh_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign finish    = (state_ff == S_READ) && slot_free;

   always_comb begin
      sum      = {1'b0, rd_data} + SUM_W'(item_ff.increment);
      sat      = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
      cnt      = dec_ff.add_ok ? sat : (dec_ff.read_ok ? rd_data : '0);
      cnt_wide = 64'(cnt);

      rd_addr = (state_ff == S_ADDR) ? dec.addr : dec_ff.addr;

      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else begin
         wr_en   = finish && dec_ff.add_ok;
         wr_addr = dec_ff.addr;
         wr_data = sat;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      item_in      = item_ff;
      dec_in       = dec_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(MEM_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_item;
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            dec_in   = dec;
            state_in = S_READ;
         end
         S_READ: begin
            if (slot_free) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.bin_index    = dec_ff.bin_index;
               rsp_item_in.type_code    = dec_ff.type_code;
               rsp_item_in.count_value  = cnt_wide[OUT_COUNT_W-1:0];
               rsp_item_in.no_immediate = dec_ff.no_immediate;
               rsp_item_in.bad_type     = dec_ff.bad_type;
               state_in                 = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      dec_ff      <= dec_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_accept_starts_lookup: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_ADDR)
      else $error("accepted item did not enter lookup");

   a_new_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_READ)
      else $error("result raised outside the update step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> $stable(rsp_item_ff))
      else $error("pending result overwritten");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_item_ff.no_immediate && rsp_item_ff.bad_type))
      else $error("both flags set");

   a_write_only_on_add: assert property (@(posedge clock) disable iff (reset)
      wr_en && state_ff != S_CLEAR |-> dec_ff.add_ok && state_ff == S_READ)
      else $error("counter write without a valid add");

endmodule
